@@ sv/tdbf_pkg.sv @@
// shared constants, microcode types and the microcode table for the tempo divider search
package tdbf_pkg;

    localparam int RATE_COUNT  = 30;
    localparam int MAX_DIVIDER = 255;
    localparam int CENTER_RATE = 50;
    localparam int ROWS_MAX    = 64;
    localparam int RATE_SCALE  = 60;
    localparam int TEMPO_SCALE = 60 * 256;
    localparam int BEST_INIT   = 256;

    localparam int TARGET_W = 8;
    localparam int ROWS_W   = 7;
    localparam int RATE_W   = 7;
    localparam int DIV_W    = 8;
    localparam int POS_W    = 5;
    localparam int DEN_W    = 14;
    localparam int NUM_W    = 22;
    localparam int RHS_W    = 12;
    localparam int TEMPO_W  = 20;
    localparam int CNT_W    = 5;
    localparam int OUT_W    = 40;

    typedef logic [2:0] step_t;

    typedef enum logic [2:0]
    {
        OP_IDLE,
        OP_PREP,
        OP_RATE,
        OP_SCAN,
        OP_DRAIN,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_OUT
    } op_t;

    typedef enum logic [2:0]
    {
        C_NEXT,
        C_WAIT_IN,
        C_SCAN,
        C_RATE,
        C_DIV,
        C_OUT
    } cond_t;

    typedef struct packed
    {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    localparam step_t S_IDLE      = 3'd0;
    localparam step_t S_PREP      = 3'd1;
    localparam step_t S_RATE      = 3'd2;
    localparam step_t S_SCAN      = 3'd3;
    localparam step_t S_DRAIN     = 3'd4;
    localparam step_t S_DIV_START = 3'd5;
    localparam step_t S_DIV_WAIT  = 3'd6;
    localparam step_t S_OUT       = 3'd7;

    // control store: one word per step
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            S_IDLE:      w = '{op: OP_IDLE,      cond: C_WAIT_IN, target: S_IDLE};
            S_PREP:      w = '{op: OP_PREP,      cond: C_NEXT,    target: S_IDLE};
            S_RATE:      w = '{op: OP_RATE,      cond: C_NEXT,    target: S_IDLE};
            S_SCAN:      w = '{op: OP_SCAN,      cond: C_SCAN,    target: S_DIV_START};
            S_DRAIN:     w = '{op: OP_DRAIN,     cond: C_RATE,    target: S_RATE};
            S_DIV_START: w = '{op: OP_DIV_START, cond: C_NEXT,    target: S_IDLE};
            S_DIV_WAIT:  w = '{op: OP_DIV_WAIT,  cond: C_DIV,     target: S_DIV_WAIT};
            S_OUT:       w = '{op: OP_OUT,       cond: C_OUT,     target: S_OUT};
            default:     w = '{op: OP_IDLE,      cond: C_WAIT_IN, target: S_IDLE};
        endcase
        return w;
    endfunction

    // search order 50, 51, 49, 52, 48, ...
    function automatic logic [RATE_W-1:0] rate_at(input logic [POS_W-1:0] p);
        logic [POS_W:0] half;
        logic [RATE_W-1:0] r;
        if (p[0])
        begin
            half = ({1'b0, p} + 1'b1) >> 1;
            r = RATE_W'(CENTER_RATE) + RATE_W'(half);
        end
        else
        begin
            half = {1'b0, p} >> 1;
            r = RATE_W'(CENTER_RATE) - RATE_W'(half);
        end
        return r;
    endfunction

endpackage

@@ sv/tdbf_divider.sv @@
// restoring divider, one quotient bit per cycle
module tdbf_divider
    import tdbf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TEMPO_W-1:0] dividend,
    input  logic [DEN_W-1:0]   divisor,
    output logic               busy,
    output logic [TEMPO_W-1:0] quotient
);

    logic               busy_reg;
    logic               busy_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [TEMPO_W-1:0] quot_reg;
    logic [TEMPO_W-1:0] quot_next;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_next;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_sub;
    logic               ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quot_reg[TEMPO_W-1]};
        rem_sub   = rem_sh - {1'b0, divisor};
        ge        = rem_sh >= {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quot_next = {quot_reg[TEMPO_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(TEMPO_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

@@ sv/tempo_divider_best_fit.sv @@
// top level: microcoded best-fit search of tick rate and divider for a target tempo
//
// usage:
//   cfg_wr_en / cfg_wr_data write rows_per_beat (reset value 4); write it only while idle.
//   s_* carries one request: the target tempo in beats per minute.
//   m_* carries one result per request: tempo in 8 fraction bits, tick rate,
//   ticks per row and a found flag.
// timing:
//   a short control program steps through 30 rates; per rate it sweeps dividers
//   1..255 through a two-stage scan (error, then cross-multiplied compare), one
//   candidate per cycle, plus a setup step and a drain step per rate.
//   the final tempo comes from a bit-serial divider.
//   the search ends early on an exact match;
//   a new request is taken only after the previous result sits in the output register.
// reset:
//   the sequencer returns to idle, the output register empties, rows_per_beat is 4.
// stall:
//   when m_tready is low the finished result waits in the output register and
//   the sequencer holds on its output step; no request is lost or repeated.
module tempo_divider_best_fit
    import tdbf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [ROWS_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TARGET_W-1:0] s_tdata,   // [7:0] target_bpm
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // [19:0] tempo_fixed, [26:20] tick_rate,
                                           // [34:27] ticks_per_row, [35] fit_found
);

    uword_t uw;
    step_t  step_reg;
    step_t  step_next;

    logic [ROWS_W-1:0]   rows_reg;
    logic [ROWS_W-1:0]   rows_eff;
    logic [TARGET_W-1:0] target_reg;
    logic [DEN_W-1:0]    trows_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [RHS_W-1:0]    rhs_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    lhs_reg;
    logic [DIV_W-1:0]    div_reg;
    logic                pipe_v_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    dpipe_reg;
    logic [DIV_W-1:0]    divpipe_reg;
    logic [NUM_W-1:0]    best_num_reg;
    logic [DEN_W-1:0]    best_den_reg;
    logic [RATE_W-1:0]   best_rate_reg;
    logic [DIV_W-1:0]    best_div_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;

    logic [NUM_W+DEN_W-1:0] cand_prod;
    logic [NUM_W+DEN_W-1:0] best_prod;
    logic [NUM_W-1:0]       rhs_ext;
    logic [RATE_W-1:0]      pos_rate;
    logic                   better;
    logic                   exact;
    logic                   out_free;
    logic                   s_accept;
    logic                   div_start;
    logic                   div_busy;
    logic [TEMPO_W-1:0]     div_quot;
    logic [TEMPO_W-1:0]     div_dividend;

    assign uw = ucode(step_reg);

    always_comb
    begin
        if (rows_reg == '0)
        begin
            rows_eff = ROWS_W'(1);
        end
        else if (rows_reg > ROWS_W'(ROWS_MAX))
        begin
            rows_eff = ROWS_W'(ROWS_MAX);
        end
        else
        begin
            rows_eff = rows_reg;
        end
    end

    // exact rational compare: num/den < best_num/best_den
    assign cand_prod = {{DEN_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, best_den_reg};
    assign best_prod = {{DEN_W{1'b0}}, best_num_reg} * {{NUM_W{1'b0}}, dpipe_reg};
    assign better    = pipe_v_reg && (cand_prod < best_prod);
    assign exact     = pipe_v_reg && (num_reg == '0);
    assign rhs_ext   = {{(NUM_W-RHS_W){1'b0}}, rhs_reg};
    assign pos_rate  = rate_at(pos_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (uw.op == OP_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign div_start = (uw.op == OP_DIV_START);
    assign div_dividend = TEMPO_W'(best_rate_reg * TEMPO_SCALE);

    always_comb
    begin
        step_next = step_reg + 1'b1;
        case (uw.cond)
            C_NEXT:
            begin
                step_next = step_reg + 1'b1;
            end
            C_WAIT_IN:
            begin
                if (!s_tvalid)
                begin
                    step_next = uw.target;
                end
            end
            C_SCAN:
            begin
                if (exact)
                begin
                    step_next = uw.target;
                end
                else if (div_reg != DIV_W'(MAX_DIVIDER))
                begin
                    step_next = step_reg;
                end
            end
            C_RATE:
            begin
                if (!(exact || pos_reg == POS_W'(RATE_COUNT - 1)))
                begin
                    step_next = uw.target;
                end
            end
            C_DIV:
            begin
                if (div_busy)
                begin
                    step_next = uw.target;
                end
            end
            C_OUT:
            begin
                // the last step wraps back to idle
                if (!out_free)
                begin
                    step_next = uw.target;
                end
            end
            default:
            begin
                step_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= S_IDLE;
            pipe_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rows_reg     <= ROWS_W'(4);
        end
        else
        begin
            step_reg   <= step_next;
            pipe_v_reg <= (uw.op == OP_SCAN) && !exact;
            if (cfg_wr_en)
            begin
                rows_reg <= cfg_wr_data;
            end
            if (uw.op == OP_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_num_reg  <= num_reg;
            best_den_reg  <= dpipe_reg;
            best_rate_reg <= rate_reg;
            best_div_reg  <= divpipe_reg;
        end
        case (uw.op)
            OP_IDLE:
            begin
                if (s_accept)
                begin
                    target_reg <= s_tdata;
                end
            end
            OP_PREP:
            begin
                trows_reg     <= DEN_W'({{(DEN_W-TARGET_W){1'b0}}, target_reg}
                                 * {{(DEN_W-ROWS_W){1'b0}}, rows_eff});
                best_num_reg  <= NUM_W'(BEST_INIT);
                best_den_reg  <= DEN_W'(1);
                best_rate_reg <= '0;
                best_div_reg  <= '0;
                pos_reg       <= '0;
            end
            OP_RATE:
            begin
                rate_reg <= pos_rate;
                rhs_reg  <= RHS_W'(pos_rate * RATE_SCALE);
                den_reg  <= {{(DEN_W-ROWS_W){1'b0}}, rows_eff};
                lhs_reg  <= {{(NUM_W-DEN_W){1'b0}}, trows_reg};
                div_reg  <= DIV_W'(1);
            end
            OP_SCAN:
            begin
                num_reg     <= (lhs_reg >= rhs_ext) ? (lhs_reg - rhs_ext) : (rhs_ext - lhs_reg);
                dpipe_reg   <= den_reg;
                divpipe_reg <= div_reg;
                den_reg     <= den_reg + {{(DEN_W-ROWS_W){1'b0}}, rows_eff};
                lhs_reg     <= lhs_reg + {{(NUM_W-DEN_W){1'b0}}, trows_reg};
                div_reg     <= div_reg + 1'b1;
            end
            OP_DRAIN:
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            OP_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {4'b0000, (best_div_reg != '0), best_div_reg,
                                    best_rate_reg, div_quot};
                end
            end
            default:
            begin
            end
        endcase
    end

    // nothing found leaves rate 0 over divisor 1, so the quotient is 0
    tdbf_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (best_den_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the tempo divider best-fit search
module testbench;
    import tdbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;  // several times the full search latency
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 64;
    localparam int LONG_HOLD      = 400;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed
    {
        logic                found;
        logic [DIV_W-1:0]    divider;
        logic [RATE_W-1:0]   rate;
        logic [TEMPO_W-1:0]  tempo;
    } fit_t;

    class fit_scoreboard;
        fit_t expected_q[$];
        int   failures;
        int   checked;

        function new();
            failures = 0;
            checked  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // search over rates and dividers that stops at the first exact fit, errors compared as fractions
        function fit_t best_fit_for(input logic [TARGET_W-1:0] bpm,
                                    input logic [ROWS_W-1:0] rows_reg);
            fit_t        f;
            logic [63:0] rows, den, lhs, rhs, err, best_num, best_den, rate;
            logic [63:0] best_rate, best_div, tempo;
            bit          hit, exact;
            int          pos, d;
            rows = (rows_reg == 0) ? 64'd1 : ((rows_reg > ROWS_MAX) ? 64'(ROWS_MAX) : 64'(rows_reg));
            best_num  = 64'(BEST_INIT);
            best_den  = 64'd1;
            best_rate = 0;
            best_div  = 0;
            hit   = 1'b0;
            exact = 1'b0;
            for (pos = 0; pos < RATE_COUNT && !exact; pos++)
            begin
                if (pos % 2 == 1)
                    rate = 64'(CENTER_RATE + (pos + 1) / 2);
                else
                    rate = 64'(CENTER_RATE - pos / 2);
                for (d = 1; d <= MAX_DIVIDER && !exact; d++)
                begin
                    den = 64'(d) * rows;
                    lhs = 64'(bpm) * den;
                    rhs = 64'(RATE_SCALE) * rate;
                    err = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
                    if (err * best_den < best_num * den)
                    begin
                        best_num  = err;
                        best_den  = den;
                        best_rate = rate;
                        best_div  = 64'(d);
                        hit = 1'b1;
                    end
                    if (err == 0)
                        exact = 1'b1;
                end
            end
            f = '0;
            if (hit)
            begin
                tempo = (64'(TEMPO_SCALE) * best_rate) / (best_div * rows);
                if (tempo > 64'hFFFFF)
                    tempo = 64'hFFFFF;
                f.tempo   = tempo[TEMPO_W-1:0];
                f.rate    = best_rate[RATE_W-1:0];
                f.divider = best_div[DIV_W-1:0];
                f.found   = 1'b1;
            end
            return f;
        endfunction

        function void note_request(input logic [TARGET_W-1:0] bpm,
                                   input logic [ROWS_W-1:0] rows_reg);
            expected_q.push_back(best_fit_for(bpm, rows_reg));
        endfunction

        function void field_check(input string name, input int unsigned exp_v,
                                  input int unsigned act_v);
            if (exp_v != act_v)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch on result %0d, %s: expected %0d, got %0d",
                             checked, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input logic [OUT_W-1:0] data);
            fit_t want, got;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result with no request outstanding: %h", data);
                return;
            end
            want = expected_q.pop_front();
            got  = data[$bits(fit_t)-1:0];
            field_check("tempo_fixed", want.tempo, got.tempo);
            field_check("tick_rate", want.rate, got.rate);
            field_check("ticks_per_row", want.divider, got.divider);
            field_check("fit_found", want.found, got.found);
            checked++;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [ROWS_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TARGET_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    fit_scoreboard     sb = new();
    logic [ROWS_W-1:0] rows_now = ROWS_W'(4);
    bit                source_gaps = 1'b1;
    bit                sink_gaps = 1'b1;
    bit                hold_request = 1'b0;
    int                requests = 0;
    int                settings = 0;
    int                quiet_cycles = 0;

    tempo_divider_best_fit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // monitor: all values read here are the ones before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_wr_en)
                rows_now = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                sb.note_request(s_tdata, rows_now);
                requests++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (sink_gaps && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_target(input logic [TARGET_W-1:0] bpm);
        int gap;
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bpm;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_rows(input logic [ROWS_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // about half the targets sit on or near an achievable tempo, so some searches end early on an exact fit
    function automatic logic [TARGET_W-1:0] pick_target(input logic [ROWS_W-1:0] rows_reg);
        int eff, rate, div, t;
        eff = (rows_reg == 0) ? 1 : ((rows_reg > ROWS_MAX) ? ROWS_MAX : int'(rows_reg));
        if ($urandom_range(0, 1) == 0)
            return TARGET_W'($urandom_range(0, 255));
        rate = $urandom_range(36, 65);
        div  = $urandom_range(1, 16);
        t = (60 * rate) / (div * eff) + $urandom_range(0, 1);
        if (t > 255)
            t = $urandom_range(0, 255);
        return TARGET_W'(t);
    endfunction

    initial
    begin
        logic [ROWS_W-1:0] rows_pick;
        int blk, n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value of rows: field extremes, alternating bits, an exact fit
        send_target(8'd0);
        send_target(8'd255);
        send_target(8'd1);
        send_target(8'd125);
        send_target(8'hAA);
        send_target(8'h55);
        send_target(8'd128);
        send_target(8'd60);

        write_rows(7'd1);
        send_target(8'd255);
        send_target(8'd60);
        send_target(8'd0);

        write_rows(7'd64);
        send_target(8'd255);
        send_target(8'd1);
        send_target(8'd0);

        // zero rows counts as one, anything above 64 as 64
        write_rows(7'd0);
        send_target(8'd250);
        write_rows(7'd127);
        send_target(8'd30);
        send_target(8'd255);
        write_rows(7'd65);
        send_target(8'd2);

        // back-pressure: a result waits in the output register while requests keep coming
        write_rows(7'd4);
        hold_request = 1'b1;
        send_target(8'd125);
        send_target(8'd150);
        send_target(8'd250);
        send_target(8'd75);
        drain_results();

        for (blk = 0; blk < 5; blk++)
        begin
            case (blk)
                0: rows_pick = ROWS_W'($urandom_range(1, 64));
                1: rows_pick = ROWS_W'($urandom_range(65, 127));
                2: rows_pick = ROWS_W'($urandom_range(1, 8));
                3: rows_pick = ROWS_W'(0);
                default: rows_pick = ROWS_W'($urandom_range(1, 64));
            endcase
            if (blk == 4)
            begin
                source_gaps = 1'b0;
                sink_gaps   = 1'b0;
            end
            write_rows(rows_pick);
            for (n = 0; n < 16; n++)
                send_target(pick_target(rows_pick));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ran %0d target tempos over %0d rows settings, %0d results checked",
                 requests, settings, sb.checked);
        $display("covered exact and inexact fits, clamped rows and output back-pressure");
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", sb.failures, sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/tdbf_pkg.sv
sv/tdbf_divider.sv
sv/tempo_divider_best_fit.sv
tb/testbench.sv
